[design/dht_pkg.sv]
// Package for the double-hashing hash table: sizes, codes, slot entry and
// the structs passed between the hash unit, the slot memory and the top level.
// No dependencies.
package dht_pkg;

  // Table geometry; SlotCount is a power of two
  localparam int SlotCount   = 16;
  localparam int StepPrime   = 7;
  localparam int PayloadBits = 64;

  // Fixed field widths of the channels
  localparam int ActionBits   = 2;
  localparam int KeyBits      = 31;
  localparam int PayFieldBits = 64;
  localparam int StatusBits   = 2;
  localparam int SlotIdxBits  = 4;

  // Derived widths
  localparam int IdxW   = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int CntW   = $clog2(SlotCount + 1);
  localparam int PrimeW = (StepPrime > 1) ? $clog2(StepPrime) : 1;
  localparam int StepW  = $clog2(StepPrime + 1);

  // Key / StepPrime by reciprocal multiplication, exact for every key
  localparam int RecipShift = KeyBits + PrimeW;
  localparam logic [KeyBits:0] RecipMul =
      (KeyBits + 1)'(((64'd1 << RecipShift) + 64'(StepPrime) - 64'd1) / 64'(StepPrime));
  localparam int ProdW = 2 * KeyBits + 1;
  localparam int QuotW = ProdW - RecipShift;

  // Action codes
  localparam logic [ActionBits-1:0] ActInsert = 2'd0;
  localparam logic [ActionBits-1:0] ActSearch = 2'd1;
  localparam logic [ActionBits-1:0] ActDelete = 2'd2;

  // Status codes
  localparam logic [StatusBits-1:0] StOk   = 2'd0;
  localparam logic [StatusBits-1:0] StMiss = 2'd1;
  localparam logic [StatusBits-1:0] StFull = 2'd2;

  typedef enum logic [1:0] {
    TagEmpty = 2'd0,
    TagUsed  = 2'd1,
    TagGone  = 2'd2
  } tag_e;

  typedef struct packed {
    tag_e                   tag;
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] payload;
  } slot_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    slot_entry_t       wr_data;
    logic [IdxW-1:0]   rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] base;
    logic [IdxW-1:0] stride;
  } hash_res_t;

endpackage

[design/dht_req_if.sv]
// Request channel of the hash table: valid/ready plus action, key, payload.
// Depends on dht_pkg.
interface dht_req_if;
  import dht_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ActionBits-1:0]   action;
  logic [KeyBits-1:0]      key;
  logic [PayFieldBits-1:0] payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink   (input valid, action, key, payload, output ready);
endinterface

[design/dht_rsp_if.sv]
// Response channel of the hash table: valid/ready plus status, slot index
// and found payload. Depends on dht_pkg.
interface dht_rsp_if;
  import dht_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [StatusBits-1:0]   status;
  logic [SlotIdxBits-1:0]  slot_index;
  logic [PayFieldBits-1:0] found_payload;

  modport source (output valid, status, slot_index, found_payload, input ready);
  modport sink   (input valid, status, slot_index, found_payload, output ready);
endinterface

[design/dht_hash.sv]
// Hash unit: forms key mod SlotCount and the probe stride
// (StepPrime - key mod StepPrime) mod SlotCount by a
// reciprocal multiply. Depends on dht_pkg.
module dht_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dht_pkg::KeyBits-1:0] key_i,
  output dht_pkg::hash_res_t         res_o
);
  import dht_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhMul,
    PhStep
  } phase_e;

  phase_e             phase_q;
  logic [KeyBits-1:0] key_q;
  logic [QuotW-1:0]   quot_q;
  logic [IdxW-1:0]    base_q;
  logic [IdxW-1:0]    stride_q;
  logic               done_q;

  logic [ProdW-1:0]   prod;
  logic [KeyBits-1:0] quot_mul;
  logic [KeyBits-1:0] rem_full;
  logic [StepW-1:0]   step_full;
  logic [IdxW-1:0]    base_d;
  logic [IdxW-1:0]    stride_d;

  // Quotient by reciprocal, then remainder and stride
  always_comb begin
    prod      = ProdW'(key_q) * ProdW'(RecipMul);
    quot_mul  = KeyBits'(quot_q) * KeyBits'(StepPrime);
    rem_full  = key_q - quot_mul;
    step_full = StepW'(StepPrime) - StepW'(rem_full[PrimeW-1:0]);
    base_d    = IdxW'(key_q % KeyBits'(SlotCount));
    stride_d  = IdxW'(int'(step_full) % SlotCount);
  end

  // Capture the key, then the quotient and base, then the stride
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      key_q    <= '0;
      quot_q   <= '0;
      base_q   <= '0;
      stride_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= (phase_q == PhStep);
      case (phase_q)
        PhIdle: begin
          if (start_i) begin
            key_q   <= key_i;
            phase_q <= PhMul;
          end
        end
        PhMul: begin
          quot_q  <= prod[ProdW-1:RecipShift];
          base_q  <= base_d;
          phase_q <= PhStep;
        end
        PhStep: begin
          stride_q <= stride_d;
          phase_q  <= PhIdle;
        end
        default: phase_q <= PhIdle;
      endcase
    end
  end

  assign res_o.done   = done_q;
  assign res_o.base   = base_q;
  assign res_o.stride = stride_q;

endmodule

[design/dht_slot_mem.sv]
// Slot store: one synchronous memory of tag, key and payload with a
// registered read, plus per-slot valid bits so unwritten slots read empty.
// Depends on dht_pkg.
module dht_slot_mem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dht_pkg::mem_req_t     req_i,
  output dht_pkg::slot_entry_t  rsp_o
);
  import dht_pkg::*;

  slot_entry_t          mem_q [SlotCount];
  logic [SlotCount-1:0] vld_q;
  slot_entry_t          rd_data_q;
  logic                 rd_vld_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  // Mark written slots; reset leaves every slot empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.rd_addr];
    end
  end

  // Never-written slot reads as empty
  always_comb begin
    rsp_o = rd_data_q;
    if (!rd_vld_q) begin
      rsp_o.tag = TagEmpty;
    end
  end

endmodule

[design/double_hash_table.sv]
// Double-hashing open-addressing hash table, one transaction at a time.
// A request passes the hash unit, the first slot read, one probe step per slot
// read and the output register; action 3 goes straight to the output register.
// The next request is taken the cycle after the result is registered.
// Reset clears all slots to empty at once; no clearing pass is needed.
module double_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  dht_req_if.sink     req_i,
  dht_rsp_if.source   rsp_o
);
  import dht_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SHash,
    SProbe,
    SDone
  } state_e;

  state_e                  state_q;
  logic [ActionBits-1:0]   act_q;
  logic [KeyBits-1:0]      key_q;
  logic [PayloadBits-1:0]  pay_q;
  logic [IdxW-1:0]         slot_q;
  logic [CntW-1:0]         cnt_q;
  logic [StatusBits-1:0]   st_q;
  logic [IdxW-1:0]         idx_q;
  logic [PayloadBits-1:0]  fpay_q;
  logic                    out_vld_q;
  logic [StatusBits-1:0]   out_st_q;
  logic [SlotIdxBits-1:0]  out_idx_q;
  logic [PayFieldBits-1:0] out_pay_q;

  hash_res_t   hres;
  mem_req_t    mreq;
  slot_entry_t mrsp;

  logic            accept;
  logic            op_valid;
  logic [IdxW:0]   slot_sum;
  logic [IdxW-1:0] slot_nx;
  logic            used;
  logic            empty;
  logic            hit;
  logic            last;
  logic            finish;
  logic [StatusBits-1:0] fin_st;
  logic [PayloadBits-1:0] fin_pay;

  assign req_i.ready = (state_q == SIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign op_valid    = (req_i.action == ActInsert) || (req_i.action == ActSearch) ||
                       (req_i.action == ActDelete);

  dht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && op_valid),
    .key_i   (req_i.key),
    .res_o   (hres)
  );

  dht_slot_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  // Next probe slot: add stride, wrap once
  always_comb begin
    slot_sum = {1'b0, slot_q} + {1'b0, hres.stride};
    if (slot_sum >= (IdxW + 1)'(SlotCount)) begin
      slot_sum = slot_sum - (IdxW + 1)'(SlotCount);
    end
    slot_nx = slot_sum[IdxW-1:0];
  end

  // Decode the slot just read and decide the probe outcome
  always_comb begin
    used    = (mrsp.tag == TagUsed);
    empty   = (mrsp.tag == TagEmpty);
    hit     = used && (mrsp.key == key_q);
    last    = (cnt_q == CntW'(SlotCount - 1));
    finish  = 1'b0;
    fin_st  = StMiss;
    fin_pay = '0;
    mreq.wr_en   = 1'b0;
    mreq.wr_addr = slot_q;
    mreq.wr_data = '{tag: TagUsed, key: key_q, payload: pay_q};
    mreq.rd_addr = (state_q == SHash) ? hres.base : slot_nx;
    if (state_q == SProbe) begin
      if (act_q == ActInsert) begin
        if (!used) begin
          finish     = 1'b1;
          fin_st     = StOk;
          mreq.wr_en = 1'b1;
        end else if (last) begin
          finish = 1'b1;
          fin_st = StFull;
        end
      end else begin
        if (hit) begin
          finish = 1'b1;
          fin_st = StOk;
          if (act_q == ActSearch) begin
            fin_pay = mrsp.payload;
          end else begin
            // Tombstone: keep the key, clear the payload
            mreq.wr_en   = 1'b1;
            mreq.wr_data = '{tag: TagGone, key: mrsp.key, payload: '0};
          end
        end else if (empty || last) begin
          finish = 1'b1;
          fin_st = StMiss;
        end
      end
    end
  end

  // Control sequence, result holding and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      act_q     <= '0;
      key_q     <= '0;
      pay_q     <= '0;
      slot_q    <= '0;
      cnt_q     <= '0;
      st_q      <= StMiss;
      idx_q     <= '0;
      fpay_q    <= '0;
      out_vld_q <= 1'b0;
      out_st_q  <= StMiss;
      out_idx_q <= '0;
      out_pay_q <= '0;
    end else begin
      // Drop the result once taken, unless a new one loads this cycle
      if (out_vld_q && rsp_o.ready && (state_q != SDone)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (accept) begin
            act_q <= req_i.action;
            key_q <= req_i.key;
            pay_q <= req_i.payload[PayloadBits-1:0];
            if (op_valid) begin
              state_q <= SHash;
            end else begin
              st_q    <= StMiss;
              idx_q   <= '0;
              fpay_q  <= '0;
              state_q <= SDone;
            end
          end
        end
        SHash: begin
          // First read goes out with the base slot
          if (hres.done) begin
            slot_q  <= hres.base;
            cnt_q   <= '0;
            state_q <= SProbe;
          end
        end
        SProbe: begin
          if (finish) begin
            st_q    <= fin_st;
            idx_q   <= (fin_st == StOk) ? slot_q : '0;
            fpay_q  <= fin_pay;
            state_q <= SDone;
          end else begin
            slot_q <= slot_nx;
            cnt_q  <= cnt_q + 1'b1;
          end
        end
        SDone: begin
          // Hold until the output register is free
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q <= 1'b1;
            out_st_q  <= st_q;
            out_idx_q <= SlotIdxBits'(idx_q);
            out_pay_q <= PayFieldBits'(fpay_q);
            state_q   <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.slot_index    = out_idx_q;
  assign rsp_o.found_payload = out_pay_q;

endmodule

[sim/dht_table_checker.sv]
`timescale 1ns / 100ps
// Checker for the double-hashing hash table: watches the request and response
// channels, keeps its own copy of the slot table and compares every response.
// Depends on dht_pkg, dht_req_if and dht_rsp_if.
module dht_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dht_req_if          req_mon,
  dht_rsp_if          rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o,
  output int unsigned ok_count_o,
  output int unsigned miss_count_o,
  output int unsigned full_count_o
);
  import dht_pkg::*;

  localparam int NoSlot = -1;

  typedef struct packed {
    logic [StatusBits-1:0]   status;
    logic [SlotIdxBits-1:0]  slot_index;
    logic [PayFieldBits-1:0] found_payload;
  } table_rsp_t;

  // Shadow copy of the slot table
  tag_e                   slot_state [SlotCount];
  logic [KeyBits-1:0]     slot_keys  [SlotCount];
  logic [PayloadBits-1:0] slot_data  [SlotCount];

  table_rsp_t  awaiting_rsp [$];
  table_rsp_t  want;
  int unsigned fails = 0;

  // Slot visited by probe number i for key k
  function automatic int unsigned probe_slot(input logic [KeyBits-1:0] k,
                                             input int unsigned i);
    int unsigned home;
    int unsigned stride;
    home   = k % SlotCount;
    stride = StepPrime - (k % StepPrime);
    return (home + i * stride) % SlotCount;
  endfunction

  // Walk the probe path: stop on a live match or an empty slot, skip tombstones
  function automatic int find_key(input logic [KeyBits-1:0] k);
    int unsigned s;
    int          hit;
    logic        stop;
    hit  = NoSlot;
    stop = 1'b0;
    for (int unsigned i = 0; i < SlotCount && !stop; i++) begin
      s = probe_slot(k, i);
      if (slot_state[s] == TagUsed && slot_keys[s] == k) begin
        hit  = int'(s);
        stop = 1'b1;
      end else if (slot_state[s] == TagEmpty) begin
        stop = 1'b1;
      end
    end
    return hit;
  endfunction

  // Apply one operation to the shadow table and return the response it gives
  function automatic table_rsp_t apply_table_op(input logic [ActionBits-1:0]   act,
                                                input logic [KeyBits-1:0]      k,
                                                input logic [PayFieldBits-1:0] pay);
    table_rsp_t  rsp;
    int unsigned s;
    int          hit;
    logic        placed;
    rsp.status        = StMiss;
    rsp.slot_index    = '0;
    rsp.found_payload = '0;
    placed            = 1'b0;
    case (act)
      ActInsert: begin
        rsp.status = StFull;
        for (int unsigned i = 0; i < SlotCount && !placed; i++) begin
          s = probe_slot(k, i);
          if (slot_state[s] != TagUsed) begin
            slot_state[s]  = TagUsed;
            slot_keys[s]   = k;
            slot_data[s]   = pay[PayloadBits-1:0];
            rsp.status     = StOk;
            rsp.slot_index = SlotIdxBits'(s);
            placed         = 1'b1;
          end
        end
      end
      ActSearch: begin
        hit = find_key(k);
        if (hit != NoSlot) begin
          rsp.status        = StOk;
          rsp.slot_index    = SlotIdxBits'(hit);
          rsp.found_payload = PayFieldBits'(slot_data[hit]);
        end
      end
      ActDelete: begin
        hit = find_key(k);
        if (hit != NoSlot) begin
          slot_state[hit] = TagGone;
          slot_data[hit]  = '0;
          rsp.status      = StOk;
          rsp.slot_index  = SlotIdxBits'(hit);
        end
      end
      default: begin
        // reserved action: table untouched, reported as not found
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        slot_state[i] = TagEmpty;
        slot_keys[i]  = '0;
        slot_data[i]  = '0;
      end
      awaiting_rsp.delete();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
      ok_count_o    <= 0;
      miss_count_o  <= 0;
      full_count_o  <= 0;
    end else begin
      // Retire the oldest expectation against each response transaction
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaiting_rsp.size() == 0) begin
          $display("%0t: response with nothing expected, actual status %0d slot %0d data %h",
                   $time, rsp_mon.status, rsp_mon.slot_index, rsp_mon.found_payload);
          fails++;
        end else begin
          want = awaiting_rsp.pop_front();
          if (rsp_mon.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp_mon.status);
            fails++;
          end
          if (rsp_mon.slot_index !== want.slot_index) begin
            $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                     $time, want.slot_index, rsp_mon.slot_index);
            fails++;
          end
          if (rsp_mon.found_payload !== want.found_payload) begin
            $display("%0t: found_payload mismatch, expected %h, actual %h",
                     $time, want.found_payload, rsp_mon.found_payload);
            fails++;
          end
          case (want.status)
            StOk:    ok_count_o   <= ok_count_o + 1;
            StFull:  full_count_o <= full_count_o + 1;
            default: miss_count_o <= miss_count_o + 1;
          endcase
        end
      end
      // Predict each request transaction in acceptance order
      if (req_mon.valid && req_mon.ready) begin
        awaiting_rsp.push_back(apply_table_op(req_mon.action, req_mon.key, req_mon.payload));
      end
      outstanding_o <= awaiting_rsp.size();
      fail_count_o  <= fails;
    end
  end

endmodule

[sim/tb_double_hash_table.sv]
`timescale 1ns / 100ps
// Top of the hash table testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on dht_pkg, both channel interfaces,
// double_hash_table and dht_table_checker.
module tb_double_hash_table;
  import dht_pkg::*;

  localparam logic [ActionBits-1:0] ActReserved = 2'd3;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleWait  = 40;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned RoundCount  = 27;
  localparam int unsigned RoundLength = 40;
  localparam int unsigned HoldLength  = 300;

  typedef enum logic [1:0] {
    RdyAlways,
    RdyCoin,
    RdyPeriodic,
    RdySparse
  } rdy_mode_e;

  logic clk_i;
  logic rst_ni;

  dht_req_if req_if ();
  dht_rsp_if rsp_if ();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned ok_count;
  int unsigned miss_count;
  int unsigned full_count;

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  logic        gaps_on    = 1'b1;
  int unsigned cycle_cnt  = 0;
  int unsigned hold_count = 0;

  logic [KeyBits-1:0] key_pool [PoolSize];

  double_hash_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  dht_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .ok_count_o    (ok_count),
    .miss_count_o  (miss_count),
    .full_count_o  (full_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_cnt, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response back-pressure: random modes, plus long hold-offs at set points
  rdy_mode_e   rdy_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  int unsigned next_hold_at;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rdy_mode     <= RdyAlways;
      mode_left    <= 0;
      hold_left    <= 0;
      next_hold_at <= 350;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (items_sent >= next_hold_at) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HoldLength;
      next_hold_at <= next_hold_at + 500;
      hold_count   <= hold_count + 1;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  <= rdy_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(40, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rdy_mode)
        RdyAlways:   rsp_if.ready <= 1'b1;
        RdyCoin:     rsp_if.ready <= 1'($urandom_range(0, 1));
        RdyPeriodic: rsp_if.ready <= (cycle_cnt[1:0] != 2'd0);
        default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one request and hold it until the transaction completes; bursts
  // end in a random idle gap when gaps are enabled
  task automatic offer_item(input logic [ActionBits-1:0]   act,
                            input logic [KeyBits-1:0]      k,
                            input logic [PayFieldBits-1:0] pay);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(1, 10) : 0;
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.key     <= k;
    req_if.payload <= pay;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent <= items_sent + 1;
  endtask

  // Stop offering and wait until every expected response has arrived
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    logic [ActionBits-1:0] act;
    logic [KeyBits-1:0]    k;
    int unsigned           ins_pct;
    int unsigned           r;

    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.action  <= ActInsert;
    req_if.key     <= '0;
    req_if.payload <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Key extremes, tombstones, reserved action
    offer_item(ActInsert, '0, '1);
    offer_item(ActInsert, '1, '0);
    offer_item(ActSearch, '0, '0);
    offer_item(ActSearch, '1, '1);
    offer_item(ActSearch, 31'd1234, '0);
    offer_item(ActDelete, '0, '0);
    offer_item(ActSearch, '0, '0);
    offer_item(ActDelete, '0, '0);
    offer_item(ActReserved, '1, '1);
    // Duplicate keys: search and delete hit the first copy on the path
    offer_item(ActInsert, 31'd5, 64'h0123_4567_89ab_cdef);
    offer_item(ActInsert, 31'd5, 64'hfedc_ba98_7654_3210);
    offer_item(ActSearch, 31'd5, '0);
    offer_item(ActDelete, 31'd5, '0);
    offer_item(ActSearch, 31'd5, '0);
    // Key 3 has stride 4, so its path covers only four slots: fill it
    repeat (5) offer_item(ActInsert, 31'd3, {$urandom, $urandom});
    // Key 115 walks the same path: full-path miss, then reuse of a tombstone
    offer_item(ActSearch, 31'd115, '0);
    offer_item(ActDelete, 31'd3, '0);
    offer_item(ActInsert, 31'd115, 64'haaaa_5555_aaaa_5555);
    offer_item(ActSearch, 31'd115, '1);
    drain_responses();

    // Key pool: extremes, random keys and keys sharing probe paths
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) begin
      if (i % 2 == 0) begin
        key_pool[i] = KeyBits'($urandom);
      end else begin
        key_pool[i] = KeyBits'($urandom_range(0, 15) + 112 * $urandom_range(0, 4));
      end
    end

    // Random rounds, each with its own insert mix
    for (int rnd = 0; rnd < RoundCount; rnd++) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 20;
        1:       ins_pct = 50;
        default: ins_pct = 80;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < RoundLength; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          act = ActReserved;
        end else if (r < 2 + ins_pct) begin
          act = ActInsert;
        end else if (r < 2 + ins_pct + (98 - ins_pct) * 6 / 10) begin
          act = ActSearch;
        end else begin
          act = ActDelete;
        end
        if ($urandom_range(0, 9) == 0) begin
          k = KeyBits'($urandom);
        end else begin
          k = key_pool[$urandom_range(0, PoolSize - 1)];
        end
        offer_item(act, k, {$urandom, $urandom});
      end
      if (rnd % 5 == 4) begin
        drain_responses();
      end
    end

    drain_responses();
    repeat (SettleWait) @(posedge clk_i);

    $display("Sent %0d requests: %0d succeeded, %0d not found, %0d table full",
             items_sent, ok_count, miss_count, full_count);
    $display("Receiver long hold-offs: %0d, run length %0d cycles", hold_count, cycle_cnt);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
